// ===== rtl/poly_pkg.sv =====
`timescale 1ns / 1ps

package poly_pkg;

    // Q16.16 word
    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;

    // full product and post-shift sum widths
    localparam int PROD_W = 2 * DATA_W;
    localparam int SUM_W  = PROD_W - FRAC_W + 1;

    // coefficient bank
    localparam int NUM_COEFS   = 8;
    localparam int COEF_IDX_W  = 3;

    // saturation limits
    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // word handed from cell to cell
    typedef struct packed {
        logic [DATA_W-1:0] x;
        logic [DATA_W-1:0] acc;
        logic              ovf;
    } t_item;

endpackage

// ===== rtl/poly_cell.sv =====
`timescale 1ns / 1ps

// One Horner step: acc <= sat(floor(acc * x / 2^16) + coef).
// Stage A holds the product, stage B the saturated sum.
module poly_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [poly_pkg::DATA_W-1:0]       i_coef,
    input  logic                              i_up_valid,
    output logic                              o_up_ready,
    input  poly_pkg::t_item                   i_up_item,
    output logic                              o_dn_valid,
    input  logic                              i_dn_ready,
    output poly_pkg::t_item                   o_dn_item
);

    localparam int DataW = poly_pkg::DATA_W;
    localparam int FracW = poly_pkg::FRAC_W;
    localparam int ProdW = poly_pkg::PROD_W;
    localparam int SumW  = poly_pkg::SUM_W;

    logic                    r_a_valid;
    logic signed [ProdW-1:0] r_a_prod;
    logic [DataW-1:0]        r_a_x;
    logic                    r_a_ovf;

    logic                    r_b_valid;
    poly_pkg::t_item         r_b_item;

    logic                    w_a_ready;
    logic                    w_b_ready;
    logic signed [ProdW-1:0] w_prod;
    logic signed [SumW-1:0]  w_sum;
    logic                    w_in_range;
    logic [DataW-1:0]        n_acc;
    logic                    n_ovf;

    assign w_b_ready  = !r_b_valid || i_dn_ready;
    assign w_a_ready  = !r_a_valid || w_b_ready;
    assign o_up_ready = w_a_ready;

    // both operands are sign-extended 32-bit values, so the product fits exactly
    assign w_prod = ProdW'($signed(i_up_item.acc)) * ProdW'($signed(i_up_item.x));

    // arithmetic shift drops the low fraction bits: floor towards minus infinity
    assign w_sum = SumW'(r_a_prod >>> FracW) + SumW'($signed(i_coef));

    assign w_in_range = (&w_sum[SumW-1:DataW-1]) || !(|w_sum[SumW-1:DataW-1]);

    always_comb begin
        if (w_in_range) begin
            n_acc = w_sum[DataW-1:0];
            n_ovf = r_a_ovf;
        end else begin
            n_acc = w_sum[SumW-1] ? poly_pkg::SAT_MIN : poly_pkg::SAT_MAX;
            n_ovf = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (w_a_ready) begin
                r_a_valid <= i_up_valid;
            end
            if (w_b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_up_valid && w_a_ready) begin
            r_a_prod <= w_prod;
            r_a_x    <= i_up_item.x;
            r_a_ovf  <= i_up_item.ovf;
        end
        if (r_a_valid && w_b_ready) begin
            r_b_item.x   <= r_a_x;
            r_b_item.acc <= n_acc;
            r_b_item.ovf <= n_ovf;
        end
    end

    assign o_dn_valid = r_b_valid;
    assign o_dn_item  = r_b_item;

endmodule

// ===== rtl/polynomial_evaluator.sv =====
`timescale 1ns / 1ps
// Each Horner cell has a product register and a sum register.
// Throughput: one word per cycle while the result side keeps taking words.
// Backpressure ripples cell by cell, so empty stages keep absorbing words while a result waits.
// Reset (i_rst_n low, synchronous): pipeline emptied, all coefficients cleared to zero.
// Configuration writes are taken every cycle (o_cfg_ready tied high).

module polynomial_evaluator #(
    parameter int MAX_DEGREE = 7
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [poly_pkg::COEF_IDX_W-1:0]      i_cfg_index,
    input  logic [poly_pkg::DATA_W-1:0]          i_cfg_data,
    // argument words
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [poly_pkg::DATA_W-1:0]   i_arg_x,
    // result words
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [poly_pkg::DATA_W-1:0]   o_poly_value,
    output logic                                 o_overflow
);

    localparam int DataW = poly_pkg::DATA_W;

    // Coefficient bank; each cell reads its own fixed entry.
    logic [DataW-1:0] r_coef [poly_pkg::NUM_COEFS];

    // Chain links: index 0 is the input port, index MAX_DEGREE the last cell.
    logic            w_valid [MAX_DEGREE+1];
    logic            w_ready [MAX_DEGREE+1];
    poly_pkg::t_item w_item  [MAX_DEGREE+1];

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < poly_pkg::NUM_COEFS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg_valid) begin
            r_coef[i_cfg_index] <= i_cfg_data;
        end
    end

    // Horner seed: accumulator starts at the top coefficient.
    assign w_valid[0]    = i_valid;
    assign o_ready       = w_ready[0];
    assign w_item[0].x   = i_arg_x;
    assign w_item[0].acc = r_coef[MAX_DEGREE];
    assign w_item[0].ovf = 1'b0;

    // Cell g folds in coefficient MAX_DEGREE-1-g.
    for (genvar g = 0; g < MAX_DEGREE; g++) begin : g_cell
        poly_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_coef     (r_coef[MAX_DEGREE-1-g]),
            .i_up_valid (w_valid[g]),
            .o_up_ready (w_ready[g]),
            .i_up_item  (w_item[g]),
            .o_dn_valid (w_valid[g+1]),
            .i_dn_ready (w_ready[g+1]),
            .o_dn_item  (w_item[g+1])
        );
    end

    // Last cell's sum register doubles as the output register.
    assign w_ready[MAX_DEGREE] = i_ready;
    assign o_valid             = w_valid[MAX_DEGREE];
    assign o_poly_value        = $signed(w_item[MAX_DEGREE].acc);
    assign o_overflow          = w_item[MAX_DEGREE].ovf;

`ifndef SYNTHESIS
    // input only stalls when every stage is full and the result is held off
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled with room in the chain");

    // a configuration write lands in the addressed coefficient
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_coef[$past(i_cfg_index)] == $past(i_cfg_data)))
        else $error("coefficient write lost");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid straight after reset");
`endif

endmodule

// ===== sim/polynomial_evaluator_tb.sv =====
`timescale 1ns / 1ps

typedef logic [poly_pkg::DATA_W-1:0] q16_t;
typedef q16_t coef_bank_t [poly_pkg::NUM_COEFS];

typedef enum logic [poly_pkg::COEF_IDX_W-1:0] {
    REG_COEF_0, REG_COEF_1, REG_COEF_2, REG_COEF_3,
    REG_COEF_4, REG_COEF_5, REG_COEF_6, REG_COEF_7
} coef_reg_e;

typedef enum int {BANK_FULL_RANGE, BANK_SMALL, BANK_EXTREME, BANK_FRACTION} bank_mode_e;

typedef struct packed {
    q16_t value;
    logic ovf;
} poly_result_t;

// Mirrors the coefficient bank and holds the values owed by the pipeline, oldest first.
class horner_checker #(int DEGREE = 7);
    q16_t         coef [poly_pkg::NUM_COEFS];
    poly_result_t owed_values [$];
    int           errors;
    int           saturated;

    function new();
        foreach (coef[i]) coef[i] = '0;
        errors    = 0;
        saturated = 0;
    endfunction

    function void note_coef(coef_reg_e idx, q16_t data);
        coef[idx] = data;
    endfunction

    // Horner from the top coefficient down: floor after each product, clamp after each sum.
    function void note_arg(q16_t x);
        longint       xs;
        longint       acc;
        longint       sum;
        poly_result_t r;
        xs    = longint'($signed(x));
        acc   = longint'($signed(coef[DEGREE]));
        r.ovf = 1'b0;
        for (int i = DEGREE - 1; i >= 0; i--) begin
            sum = ((acc * xs) >>> poly_pkg::FRAC_W) + longint'($signed(coef[i]));
            if (sum > longint'($signed(poly_pkg::SAT_MAX))) begin
                sum   = longint'($signed(poly_pkg::SAT_MAX));
                r.ovf = 1'b1;
            end else if (sum < longint'($signed(poly_pkg::SAT_MIN))) begin
                sum   = longint'($signed(poly_pkg::SAT_MIN));
                r.ovf = 1'b1;
            end
            acc = sum;
        end
        r.value = q16_t'(acc);
        owed_values.push_back(r);
    endfunction

    function void check_result(q16_t value, logic ovf);
        poly_result_t e;
        if (owed_values.size() == 0) begin
            $error("result word with nothing owed: poly_value %h overflow %b", value, ovf);
            errors++;
            return;
        end
        e = owed_values.pop_front();
        if (e.ovf) saturated++;
        if (value !== e.value) begin
            $error("poly_value mismatch: expected %h, actual %h", e.value, value);
            errors++;
        end
        if (ovf !== e.ovf) begin
            $error("overflow mismatch: expected %b, actual %b", e.ovf, ovf);
            errors++;
        end
    endfunction

    function int owed();
        return owed_values.size();
    endfunction
endclass

module polynomial_evaluator_tb;

    localparam int MAX_DEGREE     = 7;
    // pipeline depth: a product and a sum register per Horner cell
    localparam int LATENCY        = 2 * MAX_DEGREE;
    // long receiver stall, well beyond the pipeline's capacity
    localparam int HOLD_CYCLES    = 300;
    // cycles with no word moving on any channel before giving up
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_WORDS    = 48;
    localparam int HOLD_WORDS     = 64;
    localparam int RANDOM_PHASES  = 8;

    // handy Q16.16 values
    localparam q16_t ONE       = 32'h0001_0000;
    localparam q16_t MINUS_ONE = 32'hFFFF_0000;
    localparam q16_t HALF      = 32'h0000_8000;
    localparam q16_t LSB       = 32'h0000_0001;
    localparam q16_t MINUS_LSB = 32'hFFFF_FFFF;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    logic [poly_pkg::COEF_IDX_W-1:0] i_cfg_index;
    logic [poly_pkg::DATA_W-1:0]     i_cfg_data;
    logic i_valid;
    logic o_ready;
    logic signed [poly_pkg::DATA_W-1:0] i_arg_x;
    logic o_valid;
    logic i_ready;
    logic signed [poly_pkg::DATA_W-1:0] o_poly_value;
    logic o_overflow;

    horner_checker #(MAX_DEGREE) sb;

    // words seen on each channel, bumped at the rising edge; then banks written and long stalls done
    int n_args    = 0;
    int n_results = 0;
    int n_cfg     = 0;
    int n_banks   = 0;
    int holds_done = 0;

    // knobs shared between the sender and the receiver
    bit send_gaps_on = 1'b1;
    bit recv_gaps_on = 1'b1;
    bit hold_req     = 1'b0;

    polynomial_evaluator #(
        .MAX_DEGREE(MAX_DEGREE)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_arg_x      (i_arg_x),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_poly_value (o_poly_value),
        .o_overflow   (o_overflow)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Sampling at the rising edge: every handshake is counted and scored here.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                sb.note_coef(coef_reg_e'(i_cfg_index), i_cfg_data);
                n_cfg++;
            end
            if (i_valid && o_ready) begin
                sb.note_arg(i_arg_x);
                n_args++;
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_poly_value, o_overflow);
                n_results++;
            end
        end
    end

    // Watchdog: counts cycles with no word moving on any channel.
    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                idle = 0;
            else
                idle++;
        end
        $display("simulation failed");
        $finish;
    end

    // Result side: a random hold-off before each word while gaps are on, or a long stall on request.
    initial begin : result_sink
        int low;
        int seen;
        bit holding;
        i_ready = 1'b0;
        @(negedge i_clk);
        forever begin
            holding = hold_req;
            low = holding ? HOLD_CYCLES : (recv_gaps_on ? $urandom_range(0, 19) : 0);
            if (low > 0) begin
                i_ready <= 1'b0;
                repeat (low) @(negedge i_clk);
            end
            if (holding) begin
                hold_req = 1'b0;
                holds_done++;
            end
            i_ready <= 1'b1;
            seen = n_results;
            do @(negedge i_clk); while (n_results == seen);
        end
    end

    function automatic q16_t pick_extreme();
        case ($urandom_range(0, 6))
            0: return poly_pkg::SAT_MAX;
            1: return poly_pkg::SAT_MIN;
            2: return '0;
            3: return ONE;
            4: return MINUS_ONE;
            5: return LSB;
            default: return MINUS_LSB;
        endcase
    endfunction

    // Small arguments (so that results stay in range) as often as full-range ones, plus corner values.
    function automatic q16_t rand_arg();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return q16_t'($urandom_range(0, 4 * ONE)) - 2 * ONE;
        else if (sel < 8)
            return q16_t'($urandom);
        else
            return pick_extreme();
    endfunction

    task automatic fill_bank(input bank_mode_e mode, output coef_bank_t bank);
        int top;
        // small banks get a random degree; coefficients above it are zero
        top = $urandom_range(1, MAX_DEGREE);
        for (int i = 0; i < poly_pkg::NUM_COEFS; i++) begin
            case (mode)
                BANK_FULL_RANGE: bank[i] = q16_t'($urandom);
                BANK_SMALL:      bank[i] = (i <= top) ?
                                     q16_t'($urandom_range(0, 4 * ONE)) - 2 * ONE : '0;
                BANK_EXTREME:    bank[i] = pick_extreme();
                default:         bank[i] = q16_t'($urandom_range(0, 2 * ONE - 2)) - (ONE - 1);
            endcase
        end
    endtask

    // All eight registers, back to back; valid stays high across the burst.
    task automatic write_bank(input coef_bank_t bank);
        int seen;
        for (int i = 0; i < poly_pkg::NUM_COEFS; i++) begin
            i_cfg_index <= coef_reg_e'(i);
            i_cfg_data  <= bank[i];
            i_cfg_valid <= 1'b1;
            seen = n_cfg;
            do @(negedge i_clk); while (n_cfg == seen);
        end
        i_cfg_valid <= 1'b0;
        n_banks++;
    endtask

    // Entered at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_arg(input q16_t x);
        int gap;
        int seen;
        gap = send_gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_arg_x <= x;
        i_valid <= 1'b1;
        seen = n_args;
        do @(negedge i_clk); while (n_args == seen);
    endtask

    // Stop offering, let every owed word come back, then give the pipe its depth again.
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.owed() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    initial begin : stimulus
        coef_bank_t bank;
        bank_mode_e mode;
        int         words;
        q16_t       probe_mid [5];
        q16_t       probe_sat [5];

        sb          = new();
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_COEF_0;
        i_cfg_data  = '0;
        i_valid     = 1'b0;
        i_arg_x     = '0;

        // arguments probing rounding and sign for the identity and alternating banks
        probe_mid = '{poly_pkg::SAT_MAX, poly_pkg::SAT_MIN, MINUS_LSB, HALF, MINUS_ONE};
        // arguments for the all-max and all-min banks, which saturate hard
        probe_sat = '{ONE, MINUS_ONE, '0, poly_pkg::SAT_MAX, LSB};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // coefficients straight out of reset: every value must be zero
        send_arg(poly_pkg::SAT_MAX);
        send_arg(poly_pkg::SAT_MIN);
        send_arg('0);

        // identity polynomial, p(x) = x
        wait_drained();
        bank = '{default: '0};
        bank[REG_COEF_1] = ONE;
        write_bank(bank);
        foreach (probe_mid[i]) send_arg(probe_mid[i]);

        // every coefficient at the positive limit
        wait_drained();
        bank = '{default: poly_pkg::SAT_MAX};
        write_bank(bank);
        foreach (probe_sat[i]) send_arg(probe_sat[i]);

        // every coefficient at the negative limit
        wait_drained();
        bank = '{default: poly_pkg::SAT_MIN};
        write_bank(bank);
        foreach (probe_sat[i]) send_arg(probe_sat[i]);

        // alternating +1 / -1, exercises cancellation and floor rounding of tiny negatives
        wait_drained();
        for (int i = 0; i < poly_pkg::NUM_COEFS; i++)
            bank[i] = (i % 2 == 0) ? ONE : MINUS_ONE;
        write_bank(bank);
        foreach (probe_mid[i]) send_arg(probe_mid[i]);

        // random part: each bank style twice, with varied idling on both sides
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            mode = bank_mode_e'(ph % 4);
            fill_bank(mode, bank);
            wait_drained();
            write_bank(bank);
            send_gaps_on = (ph % 3 != 0);
            recv_gaps_on = (ph % 3 != 1);
            words = PHASE_WORDS;
            if (ph == 6) recv_gaps_on = 1'b0;
            if (ph == 2) begin
                // receiver stalls long while words keep coming: pipe fills, o_ready drops
                send_gaps_on = 1'b0;
                hold_req     = 1'b1;
                words        = HOLD_WORDS;
            end
            for (int k = 0; k < words; k++) begin
                if (ph == 5 && k == words / 2) wait_drained();
                send_arg(rand_arg());
            end
        end

        wait_drained();

        $display("covered %0d argument words, %0d results, %0d coefficient banks",
                 n_args, n_results, n_banks);
        $display("%0d results saturated, %0d long receiver stalls", sb.saturated, holds_done);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
